/* rtl/hzgb_pkg.sv */
// Shared types and constants for the HZ (GB2312) stream decoder.
// Holds the decode mode encoding, result kinds and the result record types.
// No dependencies; every other file in the block imports this package.
package hzgb_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CODE_W = 16;
   localparam int unsigned KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_ASCII = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GB    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UNK1  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNK2  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

   localparam logic [BYTE_W-1:0] CHAR_TILDE   = 8'h7e;
   localparam logic [BYTE_W-1:0] CHAR_LBRACE  = 8'h7b;
   localparam logic [BYTE_W-1:0] CHAR_RBRACE  = 8'h7d;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [BYTE_W-1:0] HIGH_BIT     = 8'h80;
   localparam logic [BYTE_W-1:0] LOW_MASK     = 8'h7f;

   typedef enum logic [5:0] {
      MODE_ASCII   = 6'b000001,
      MODE_TILDE   = 6'b000010,
      MODE_GB      = 6'b000100,
      MODE_GBTILDE = 6'b001000,
      MODE_GB1     = 6'b010000,
      MODE_GR1     = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } dec_out_type;

   function automatic logic is_gl(input logic [BYTE_W-1:0] b);
      return (b >= 8'h21) && (b <= 8'h7e);
   endfunction

   function automatic logic is_gr(input logic [BYTE_W-1:0] b);
      return (b >= 8'ha1) && (b <= 8'hfe);
   endfunction

endpackage

/* rtl/hzgb_decode.sv */
// Decode stage of the HZ stream decoder: mode and held-byte registers plus
// the combinational logic that turns one byte into up to two results.
// Depends on hzgb_pkg.
module hzgb_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [hzgb_pkg::BYTE_W-1:0] in_byte,
   input  logic                       stream_end,
   output hzgb_pkg::dec_out_type      dec_out
);
   import hzgb_pkg::*;

   mode_type            mode_ff, mode_in, mode_step;
   logic [BYTE_W-1:0]   held_ff, held_in, held_step;
   logic                emit;
   logic [KIND_W-1:0]   emit_kind;
   logic [CODE_W-1:0]   emit_code;
   logic [CODE_W-1:0]   pair;
   logic [CODE_W-1:0]   single;
   logic                low_gl;
   logic                pending;

   assign pair   = {held_ff, in_byte};
   assign single = {{(CODE_W-BYTE_W){1'b0}}, in_byte};
   assign low_gl = is_gl(in_byte & LOW_MASK);

   always_comb begin
      mode_step = MODE_ASCII;
      held_step = held_ff;
      emit      = 1'b0;
      emit_kind = KIND_ASCII;
      emit_code = single;
      unique case (mode_ff)
         MODE_TILDE: begin
            if (in_byte == CHAR_LBRACE) begin
               mode_step = MODE_GB;
            end else if (in_byte == CHAR_TILDE) begin
               emit = 1'b1;
            end else if (in_byte != CHAR_NEWLINE) begin
               emit      = 1'b1;
               emit_kind = KIND_UNK2;
               emit_code = pair;
            end
         end
         MODE_GBTILDE: begin
            if (in_byte != CHAR_RBRACE && in_byte != CHAR_NEWLINE) begin
               emit      = 1'b1;
               emit_kind = low_gl ? KIND_GB : KIND_UNK2;
               emit_code = pair;
               mode_step = MODE_GB;
            end
         end
         MODE_GB: begin
            mode_step = MODE_GB;
            if (in_byte == CHAR_TILDE) begin
               held_step = in_byte;
               mode_step = MODE_GBTILDE;
            end else if (low_gl) begin
               held_step = in_byte;
               mode_step = MODE_GB1;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_UNK1;
            end
         end
         MODE_GB1: begin
            emit      = 1'b1;
            emit_kind = low_gl ? KIND_GB : KIND_UNK2;
            emit_code = pair;
            mode_step = MODE_GB;
         end
         MODE_GR1: begin
            emit      = 1'b1;
            emit_kind = is_gr(in_byte) ? KIND_GB : KIND_UNK2;
            emit_code = pair;
         end
         default: begin
            if (in_byte == CHAR_TILDE) begin
               held_step = in_byte;
               mode_step = MODE_TILDE;
            end else if (is_gr(in_byte)) begin
               held_step = in_byte;
               mode_step = MODE_GR1;
            end else begin
               emit      = 1'b1;
               emit_kind = ((in_byte & HIGH_BIT) != '0) ? KIND_UNK1 : KIND_ASCII;
            end
         end
      endcase
   end

   assign pending = (mode_step == MODE_TILDE) || (mode_step == MODE_GBTILDE) ||
                    (mode_step == MODE_GB1) || (mode_step == MODE_GR1);

   always_comb begin
      dec_out.first  = '{kind: emit_kind, code: emit_code, last: !stream_end};
      dec_out.second = '{kind: KIND_END, code: '0, last: 1'b1};
      dec_out.count  = emit ? 2'd1 : 2'd0;
      mode_in        = mode_step;
      held_in        = held_step;
      if (stream_end) begin
         mode_in = MODE_ASCII;
         held_in = '0;
         if (pending) begin
            dec_out.first = '{kind: KIND_UNK1,
                              code: {{(CODE_W-BYTE_W){1'b0}}, held_step},
                              last: 1'b0};
            dec_out.count = 2'd2;
         end else if (emit) begin
            dec_out.count = 2'd2;
         end else begin
            dec_out.first = dec_out.second;
            dec_out.count = 2'd1;
         end
      end else begin
         dec_out.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ASCII;
         held_ff <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

/* rtl/hzgb_out_buf.sv */
// Two-entry result register of the HZ stream decoder; presents one result
// per cycle while the receiver is ready, and takes a new decoded byte as soon as its last result leaves.
// Depends on hzgb_pkg.
module hzgb_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  hzgb_pkg::dec_out_type  dec_out,
   input  logic                   out_ready,
   output logic                   can_load,
   output logic                   out_valid,
   output hzgb_pkg::result_type   out_result
);
   import hzgb_pkg::*;

   logic       v0_ff, v0_in, v1_ff, v1_in;
   result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic       pop;

   assign pop        = v0_ff && out_ready;
   assign can_load   = !v0_ff || (pop && !v1_ff);
   assign out_valid  = v0_ff;
   assign out_result = slot0_ff;

   always_comb begin
      v0_in    = v0_ff;
      v1_in    = v1_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         v0_in    = dec_out.count != 2'd0;
         v1_in    = dec_out.count == 2'd2;
         slot0_in = dec_out.first;
         slot1_in = dec_out.second;
      end else if (pop) begin
         v0_in    = v1_ff;
         v1_in    = 1'b0;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_order: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> v0_ff)
      else $error("second result held without a first");
   a_second_end: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (slot1_ff.kind == KIND_END && slot1_ff.last))
      else $error("second result is not a final end marker");
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> !slot0_ff.last)
      else $error("first of two results marked last");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (v0_ff && !v1_ff) |-> slot0_ff.last)
      else $error("only remaining result not marked last");

endmodule

/* rtl/hz_gb2312_stream_decoder_core.sv */
// Top level of the HZ (GB2312) stream decoder: input register, decode stage
// and result register. Depends on hzgb_pkg, hzgb_decode and hzgb_out_buf.
//
// Usage: raw bytes of an HZ stream arrive on the req_ channel, one byte per
// request, with req_tlast set on the last byte of a stream. Decoded items
// leave on the rsp_ channel: rsp_tdata carries the character or code,
// rsp_tuser its kind, and rsp_tlast marks the last result a byte produced.
// A byte yields zero, one or two results; the last byte of a stream always
// yields an end marker, preceded by its own result or by a flushed unknown
// byte if a sequence was left open.
// Order: an accepted byte is held in the input register, decoded
// combinationally, and loaded into the result register, which presents it.
// Throughput: one request per cycle while the receiver is ready. A byte that
// yields two results holds the result register until both leave, which slows such bytes.
// Reset clears the decode mode to ASCII with nothing pending and empties
// both registers. When the receiver stalls, results are held stable, the
// input register fills and req_tready falls until space is freed.
module hz_gb2312_stream_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [7:0] in_byte
   input  logic                         req_tlast,  // stream_end
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,  // [15:0] code
   output logic [hzgb_pkg::KIND_W-1:0]  rsp_tuser,  // [2:0] kind
   output logic                         rsp_tlast   // run_last
);
   import hzgb_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              can_load;
   logic              load;
   logic              req_accept;
   dec_out_type       dec_out;
   result_type        out_result;

   assign load        = in_valid_ff && can_load;
   assign req_tready  = !in_valid_ff || can_load;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   hzgb_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (load),
      .in_byte    (in_byte_ff),
      .stream_end (in_last_ff),
      .dec_out    (dec_out)
   );

   hzgb_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .dec_out    (dec_out),
      .out_ready  (rsp_tready),
      .can_load   (can_load),
      .out_valid  (rsp_tvalid),
      .out_result (out_result)
   );

   assign rsp_tdata = out_result.code;
   assign rsp_tuser = out_result.kind;
   assign rsp_tlast = out_result.last;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for hz_gb2312_stream_decoder_core, the HZ byte stream decoder.
// A clocked driver sends bytes from a queue, a model of the decoder predicts the results,
// and a clocked monitor compares them. Depends on hzgb_pkg and the decoder RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hzgb_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_BYTES = 170;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } hz_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = 8'h00;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic              rsp_tlast;

   hz_byte_type hz_bytes[$];
   result_type  decoded_symbols[$];
   mode_type    decode_state = MODE_ASCII;
   logic [7:0]  lead_byte = 8'h00;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   hz_gb2312_stream_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic logic in_gl_range(input logic [7:0] b);
      return b >= 8'h21 && b <= 8'h7e;
   endfunction

   function automatic logic in_gr_range(input logic [7:0] b);
      return b >= 8'ha1 && b <= 8'hfe;
   endfunction

   function automatic result_type symbol(input logic [KIND_W-1:0] k, input logic [15:0] c);
      return {k, c, 1'b0};
   endfunction

   // Advances the decoder state by one byte and queues the symbols it yields.
   function automatic void decode_hz_byte(input logic [7:0] b, input logic eos);
      result_type made[$];
      logic [15:0] pair;
      pair = {lead_byte, b};
      case (decode_state)
         MODE_TILDE: begin
            if (b == CHAR_LBRACE) begin
               decode_state = MODE_GB;
            end else begin
               if (b == CHAR_TILDE) made.push_back(symbol(KIND_ASCII, {8'h00, b}));
               else if (b != CHAR_NEWLINE) made.push_back(symbol(KIND_UNK2, pair));
               decode_state = MODE_ASCII;
            end
         end
         MODE_GBTILDE: begin
            if (b == CHAR_RBRACE || b == CHAR_NEWLINE) begin
               decode_state = MODE_ASCII;
            end else begin
               made.push_back(symbol(in_gl_range(b & LOW_MASK) ? KIND_GB : KIND_UNK2, pair));
               decode_state = MODE_GB;
            end
         end
         MODE_GB: begin
            if (b == CHAR_TILDE) begin
               lead_byte = b;
               decode_state = MODE_GBTILDE;
            end else if (in_gl_range(b & LOW_MASK)) begin
               lead_byte = b;
               decode_state = MODE_GB1;
            end else begin
               made.push_back(symbol(KIND_UNK1, {8'h00, b}));
            end
         end
         MODE_GB1: begin
            made.push_back(symbol(in_gl_range(b & LOW_MASK) ? KIND_GB : KIND_UNK2, pair));
            decode_state = MODE_GB;
         end
         MODE_GR1: begin
            made.push_back(symbol(in_gr_range(b) ? KIND_GB : KIND_UNK2, pair));
            decode_state = MODE_ASCII;
         end
         default: begin
            if (b == CHAR_TILDE) begin
               lead_byte = b;
               decode_state = MODE_TILDE;
            end else if (in_gr_range(b)) begin
               lead_byte = b;
               decode_state = MODE_GR1;
            end else if (b & HIGH_BIT) begin
               made.push_back(symbol(KIND_UNK1, {8'h00, b}));
               decode_state = MODE_ASCII;
            end else begin
               made.push_back(symbol(KIND_ASCII, {8'h00, b}));
               decode_state = MODE_ASCII;
            end
         end
      endcase
      if (eos) begin
         if (decode_state inside {MODE_TILDE, MODE_GBTILDE, MODE_GB1, MODE_GR1})
            made.push_back(symbol(KIND_UNK1, {8'h00, lead_byte}));
         made.push_back(symbol(KIND_END, 16'h0000));
         decode_state = MODE_ASCII;
         lead_byte = 8'h00;
      end
      if (made.size() != 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) decoded_symbols.push_back(made[i]);
   endfunction

   function automatic void send_byte(input logic [7:0] b, input logic eos);
      hz_byte_type item;
      item.data = b;
      item.eos = eos;
      hz_bytes.push_back(item);
   endfunction

   function automatic logic [7:0] any_byte(input int unsigned lo, input int unsigned hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic logic [7:0] any_gl_byte();
      logic [7:0] v;
      v = any_byte(8'h21, 8'h7e);
      v[7] = 1'($urandom_range(0, 1));
      return v;
   endfunction

   function automatic logic [7:0] any_gr_byte();
      return any_byte(8'ha1, 8'hfe);
   endfunction

   // Builds one stream, mostly well-formed HZ text with some broken sequences and noise.
   function automatic int queue_hz_stream();
      logic [7:0] s[$];
      s = {};
      repeat ($urandom_range(1, 10)) begin
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 6)) s.push_back(any_byte(0, 8'h7f));
            2: begin
               s.push_back(CHAR_TILDE);
               s.push_back($urandom_range(0, 1) ? CHAR_TILDE : CHAR_NEWLINE);
            end
            3: repeat ($urandom_range(1, 3)) begin
               s.push_back(any_gr_byte());
               s.push_back(any_gr_byte());
            end
            4, 5, 6: begin
               s.push_back(CHAR_TILDE);
               s.push_back(CHAR_LBRACE);
               repeat ($urandom_range(1, 5)) begin
                  case ($urandom_range(0, 7))
                     0: begin
                        s.push_back(CHAR_TILDE);
                        s.push_back(any_gl_byte());
                     end
                     1: s.push_back(CHAR_NEWLINE);
                     2: s.push_back(any_byte(0, 255));
                     default: begin
                        s.push_back(any_gl_byte());
                        s.push_back(any_gl_byte());
                     end
                  endcase
               end
               case ($urandom_range(0, 4))
                  0: begin
                     s.push_back(CHAR_TILDE);
                     s.push_back(CHAR_NEWLINE);
                  end
                  1: ;
                  default: begin
                     s.push_back(CHAR_TILDE);
                     s.push_back(CHAR_RBRACE);
                  end
               endcase
            end
            7: begin
               s.push_back(CHAR_TILDE);
               s.push_back(any_byte(0, 255));
            end
            8: begin
               s.push_back(any_gr_byte());
               s.push_back(any_byte(0, 255));
            end
            default: repeat ($urandom_range(1, 4)) s.push_back(any_byte(0, 255));
         endcase
      end
      case ($urandom_range(0, 7))
         0: s.push_back(CHAR_TILDE);
         1: s.push_back(any_gr_byte());
         2: s.push_back(any_gl_byte());
         default: ;
      endcase
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
      return s.size();
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      hz_byte_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_hz_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (hz_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = hz_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_item.data;
               req_tlast <= next_item.eos;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_symbols.size() == 0) begin
               $display("%0t ns: no result expected, got kind %0d code %04h last %0d",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = decoded_symbols.pop_front();
               if (want.kind !== rsp_tuser || want.code !== rsp_tdata
                   || want.last !== rsp_tlast) begin
                  $display({"%0t ns: expected kind %0d code %04h last %0d, ",
                            "got kind %0d code %04h last %0d"},
                           $time, want.kind, want.code, want.last,
                           rsp_tuser, rsp_tdata, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      int added;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_byte(8'h41, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'ha1, 1'b0);
      send_byte(8'hfe, 1'b0);
      send_byte(8'hb0, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_LBRACE, 1'b0);
      send_byte(8'h21, 1'b0);
      send_byte(8'h7e, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0);
      send_byte(8'ha1, 1'b0);
      send_byte(8'hc1, 1'b0);
      send_byte(8'ha0, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(8'h30, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_RBRACE, 1'b0);
      send_byte(CHAR_TILDE, 1'b1);
      send_byte(8'hb5, 1'b1);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_LBRACE, 1'b0);
      send_byte(8'h50, 1'b1);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_LBRACE, 1'b0);
      send_byte(CHAR_TILDE, 1'b1);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_LBRACE, 1'b0);
      send_byte(CHAR_TILDE, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0);
      send_byte(8'h00, 1'b1);
      for (int phase = 0; phase < 4; phase++) begin
         // Each phase starts only once every request of the last one has been answered.
         while (hz_bytes.size() != 0 || req_tvalid || decoded_symbols.size() != 0)
            @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 84;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 84;
            end
            default: begin
               send_idle_pct = 30;
               recv_stall_pct = 30;
            end
         endcase
         added = 0;
         while (added < PHASE_BYTES) added += queue_hz_stream();
      end
      while (hz_bytes.size() != 0 || req_tvalid || decoded_symbols.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      if (decoded_symbols.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, decoded_symbols.size());
      end
      if (mismatches == 0 && decoded_symbols.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/hzgb_pkg.sv
rtl/hzgb_decode.sv
rtl/hzgb_out_buf.sv
rtl/hz_gb2312_stream_decoder_core.sv
dv/testbench.sv
